/* hw/rtl/ofe_pkg.sv */
package ofe_pkg;

    localparam int MUL_STEPS = 24;
    localparam int DIV_STEPS = 64;

    localparam logic [13:0] DEFAULT_CUT = 14'd307;
    localparam logic [31:0] DT_MIN      = 32'd1000;
    localparam logic [31:0] DT_MAX      = 32'd200000;
    localparam logic [47:0] TAU_K       = 48'd40743665;
    localparam logic [23:0] BETA_Q16    = 24'd39322;
    localparam logic [23:0] USEC_PER_S  = 24'd1000000;
    localparam logic [47:0] USEC_DEN    = 48'd1000000;
    localparam logic [28:0] LEAD_CAP    = 29'd2621;
    localparam logic signed [33:0] OFFSET_LIM = 34'sd26214;

    localparam logic [1:0] REG_LAT_CUT = 2'd0;
    localparam logic [1:0] REG_HORIZON = 2'd1;

    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADIV,
        ST_AXE,
        ST_DXM,
        ST_DXD,
        ST_SM,
        ST_CM,
        ST_PM,
        ST_AD,
        ST_EM,
        ST_OUTS,
        ST_LM,
        ST_LD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0] timestamp;
    } in_t;

    typedef struct packed {
        logic        offset_valid;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
    } out_t;

    typedef struct packed {
        logic        start;
        logic [47:0] a;
        logic [23:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [47:0] den;
    } div_req_t;

endpackage

/* hw/rtl/ofe_mul.sv */
module ofe_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  ofe_pkg::mul_req_t req,
    output logic              done,
    output logic [63:0]       product
);

    logic [63:0] acc_reg;
    logic [63:0] a_reg;
    logic [23:0] b_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg
                        && (cnt_reg == 5'(ofe_pkg::MUL_STEPS - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(ofe_pkg::MUL_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= {16'd0, req.a};
            b_reg   <= req.b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= {a_reg[62:0], 1'b0};
            b_reg <= {1'b0, b_reg[23:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hw/rtl/ofe_div.sv */
module ofe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ofe_pkg::div_req_t req,
    output logic              done,
    output logic [63:0]       quotient
);

    logic [63:0] num_reg;
    logic [47:0] den_reg;
    logic [48:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg[47:0], num_reg[63]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg
                        && (cnt_reg == 6'(ofe_pkg::DIV_STEPS - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(ofe_pkg::DIV_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            num_reg <= {num_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

/* hw/rtl/ofe_core.sv */
module ofe_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ofe_pkg::in_t      in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ofe_pkg::out_t     out_data,
    input  logic [13:0]       lat_cut,
    input  logic [16:0]       horizon,
    output ofe_pkg::mul_req_t mul_req,
    input  logic              mul_done,
    input  logic [63:0]       mul_p,
    output ofe_pkg::div_req_t div_req,
    input  logic              div_done,
    input  logic [63:0]       div_q
);

    ofe_pkg::state_t state_reg, state_next;

    logic signed [31:0] est_reg [3];
    logic signed [31:0] slope_reg [3];
    logic signed [31:0] origin_reg [3];
    logic signed [31:0] raw_reg [3];
    logic signed [15:0] off_reg [3];
    logic        have_reg;
    logic        origin_set_reg;
    logic [31:0] last_time_reg;
    logic [31:0] ts_reg;
    logic [17:0] dt_reg;
    logic [15:0] ad_reg;
    logic [1:0]  ax_reg;
    logic        e_neg_reg;
    logic [32:0] e_mag_reg;
    logic        diff_neg_reg;
    logic        out_valid_reg;
    ofe_pkg::out_t out_reg;

    logic        accept;
    logic [31:0] dt_wrap;
    logic [17:0] dt_in;
    logic signed [32:0] e_full;
    logic [32:0] e_mag;
    logic signed [43:0] dx;
    logic signed [44:0] diff;
    logic [44:0] diff_mag;
    logic signed [46:0] s_sum;
    logic signed [31:0] s_new;
    logic [31:0] s_new_mag;
    logic [31:0] slope_mag;
    logic [13:0] mc;
    logic [13:0] mc_ax;
    logic [23:0] fc;
    logic [41:0] pfc;
    logic signed [33:0] est_sum;
    logic [32:0] est_d;
    logic [28:0] lead_mag;
    logic signed [33:0] lead;
    logic signed [33:0] off_full;
    logic signed [15:0] off_clamp;
    logic        show;
    logic        load_out;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ofe_pkg::ST_IDLE);
    assign show = have_reg && origin_set_reg;
    assign load_out = (state_reg == ofe_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    assign dt_wrap = in_data.timestamp - last_time_reg;
    assign dt_in = (dt_wrap < ofe_pkg::DT_MIN) ? ofe_pkg::DT_MIN[17:0] :
                   (dt_wrap > ofe_pkg::DT_MAX) ? ofe_pkg::DT_MAX[17:0] : dt_wrap[17:0];

    assign e_full = {raw_reg[ax_reg][31], raw_reg[ax_reg]}
                  - {est_reg[ax_reg][31], est_reg[ax_reg]};
    assign e_mag = e_full[32] ? 33'(-e_full) : 33'(e_full);

    assign dx = e_neg_reg ? -$signed({1'b0, div_q[42:0]}) : $signed({1'b0, div_q[42:0]});
    assign diff = {dx[43], dx} - 45'(slope_reg[ax_reg]);
    assign diff_mag = diff[44] ? 45'(-diff) : 45'(diff);

    assign s_sum = diff_neg_reg ? 47'(slope_reg[ax_reg]) - $signed({2'b0, mul_p[60:16]})
                                : 47'(slope_reg[ax_reg]) + $signed({2'b0, mul_p[60:16]});
    assign s_new = (s_sum > 47'sd2147483647) ? 32'sh7FFFFFFF :
                   (s_sum < -47'sd2147483648) ? 32'sh80000000 : s_sum[31:0];
    assign s_new_mag = s_new[31] ? 32'(-s_new) : 32'(s_new);
    assign slope_mag = slope_reg[ax_reg][31] ? 32'(-slope_reg[ax_reg])
                                             : 32'(slope_reg[ax_reg]);

    assign mc = (lat_cut == 14'd0) ? ofe_pkg::DEFAULT_CUT : lat_cut;
    assign mc_ax = (ax_reg == ofe_pkg::AXIS_Z) ? {1'b0, mc[13:1]} : mc;
    assign fc = {10'd0, mc_ax} + {1'b0, mul_p[46:24]};
    assign pfc = mul_p[41:0];

    assign est_d = mul_p[48:16];
    assign est_sum = e_neg_reg ? 34'(est_reg[ax_reg]) - $signed({1'b0, est_d})
                               : 34'(est_reg[ax_reg]) + $signed({1'b0, est_d});

    assign lead_mag = (div_q[63:29] != '0 || div_q[28:0] > ofe_pkg::LEAD_CAP)
                      ? ofe_pkg::LEAD_CAP : div_q[28:0];
    assign lead = slope_reg[ax_reg][31] ? -$signed({5'd0, lead_mag})
                                        : $signed({5'd0, lead_mag});
    assign off_full = 34'(est_reg[ax_reg]) + lead - 34'(origin_reg[ax_reg]);
    assign off_clamp = (off_full > ofe_pkg::OFFSET_LIM) ? ofe_pkg::OFFSET_LIM[15:0] :
                       (off_full < -ofe_pkg::OFFSET_LIM) ? 16'(-ofe_pkg::OFFSET_LIM)
                                                          : off_full[15:0];

    always_comb
    begin
        state_next = state_reg;
        mul_req = '0;
        div_req = '0;
        case (state_reg)
            ofe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_data.opcode && have_reg)
                    begin
                        div_req.start = 1'b1;
                        div_req.num = {22'd0, dt_in, 24'd0};
                        div_req.den = {22'd0, dt_in, 8'd0} + ofe_pkg::TAU_K;
                        state_next = ofe_pkg::ST_ADIV;
                    end
                    else
                        state_next = ofe_pkg::ST_OUTS;
                end
            end
            ofe_pkg::ST_ADIV:
                if (div_done)
                    state_next = ofe_pkg::ST_AXE;
            ofe_pkg::ST_AXE:
            begin
                mul_req.start = 1'b1;
                mul_req.a = {15'd0, e_mag};
                mul_req.b = ofe_pkg::USEC_PER_S;
                state_next = ofe_pkg::ST_DXM;
            end
            ofe_pkg::ST_DXM:
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num = mul_p;
                    div_req.den = {30'd0, dt_reg};
                    state_next = ofe_pkg::ST_DXD;
                end
            ofe_pkg::ST_DXD:
                if (div_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a = {3'd0, diff_mag};
                    mul_req.b = {8'd0, ad_reg};
                    state_next = ofe_pkg::ST_SM;
                end
            ofe_pkg::ST_SM:
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a = {16'd0, s_new_mag};
                    mul_req.b = ofe_pkg::BETA_Q16;
                    state_next = ofe_pkg::ST_CM;
                end
            ofe_pkg::ST_CM:
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a = {24'd0, fc};
                    mul_req.b = {6'd0, dt_reg};
                    state_next = ofe_pkg::ST_PM;
                end
            ofe_pkg::ST_PM:
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num = {6'd0, pfc, 16'd0};
                    div_req.den = {6'd0, pfc} + ofe_pkg::TAU_K;
                    state_next = ofe_pkg::ST_AD;
                end
            ofe_pkg::ST_AD:
                if (div_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a = {15'd0, e_mag_reg};
                    mul_req.b = {8'd0, div_q[15:0]};
                    state_next = ofe_pkg::ST_EM;
                end
            ofe_pkg::ST_EM:
                if (mul_done)
                    state_next = (ax_reg == ofe_pkg::AXIS_Z) ? ofe_pkg::ST_OUTS
                                                             : ofe_pkg::ST_AXE;
            ofe_pkg::ST_OUTS:
            begin
                if (!show)
                    state_next = ofe_pkg::ST_DONE;
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a = {16'd0, slope_mag};
                    mul_req.b = {7'd0, horizon};
                    state_next = ofe_pkg::ST_LM;
                end
            end
            ofe_pkg::ST_LM:
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num = mul_p;
                    div_req.den = ofe_pkg::USEC_DEN;
                    state_next = ofe_pkg::ST_LD;
                end
            ofe_pkg::ST_LD:
                if (div_done)
                    state_next = (ax_reg == ofe_pkg::AXIS_Z) ? ofe_pkg::ST_DONE
                                                             : ofe_pkg::ST_OUTS;
            ofe_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = ofe_pkg::ST_IDLE;
            default:
                state_next = ofe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ofe_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                est_reg[i]    <= '0;
                slope_reg[i]  <= '0;
                origin_reg[i] <= '0;
            end
            have_reg       <= 1'b0;
            origin_set_reg <= 1'b0;
            last_time_reg  <= '0;
            ax_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ofe_pkg::ST_IDLE:
                    if (accept)
                    begin
                        ax_reg <= '0;
                        if (in_data.opcode)
                        begin
                            if (have_reg)
                                for (int i = 0; i < 3; i++)
                                    origin_reg[i] <= est_reg[i];
                        end
                        else if (!have_reg)
                        begin
                            est_reg[0] <= in_data.pos_x;
                            est_reg[1] <= in_data.pos_y;
                            est_reg[2] <= in_data.pos_z;
                            for (int i = 0; i < 3; i++)
                                slope_reg[i] <= '0;
                            have_reg <= 1'b1;
                            last_time_reg <= in_data.timestamp;
                            if (!origin_set_reg)
                            begin
                                origin_reg[0] <= in_data.pos_x;
                                origin_reg[1] <= in_data.pos_y;
                                origin_reg[2] <= in_data.pos_z;
                                origin_set_reg <= 1'b1;
                            end
                        end
                    end
                ofe_pkg::ST_SM:
                    if (mul_done)
                        slope_reg[ax_reg] <= s_new;
                ofe_pkg::ST_EM:
                    if (mul_done)
                    begin
                        est_reg[ax_reg] <= est_sum[31:0];
                        if (ax_reg == ofe_pkg::AXIS_Z)
                        begin
                            ax_reg <= '0;
                            last_time_reg <= ts_reg;
                            if (!origin_set_reg)
                            begin
                                for (int i = 0; i < 2; i++)
                                    origin_reg[i] <= est_reg[i];
                                origin_reg[2] <= est_sum[31:0];
                                origin_set_reg <= 1'b1;
                            end
                        end
                        else
                            ax_reg <= ax_reg + 2'd1;
                    end
                ofe_pkg::ST_LD:
                    if (div_done)
                        ax_reg <= (ax_reg == ofe_pkg::AXIS_Z) ? 2'd0 : ax_reg + 2'd1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ofe_pkg::ST_IDLE:
                if (accept)
                begin
                    raw_reg[0] <= in_data.pos_x;
                    raw_reg[1] <= in_data.pos_y;
                    raw_reg[2] <= in_data.pos_z;
                    ts_reg <= in_data.timestamp;
                    dt_reg <= dt_in;
                end
            ofe_pkg::ST_ADIV:
                if (div_done)
                    ad_reg <= div_q[15:0];
            ofe_pkg::ST_AXE:
            begin
                e_neg_reg <= e_full[32];
                e_mag_reg <= e_mag;
            end
            ofe_pkg::ST_DXD:
                if (div_done)
                    diff_neg_reg <= diff[44];
            ofe_pkg::ST_OUTS:
                if (!show)
                    for (int i = 0; i < 3; i++)
                        off_reg[i] <= '0;
            ofe_pkg::ST_LD:
                if (div_done)
                    off_reg[ax_reg] <= off_clamp;
            ofe_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.offset_valid <= show;
                    out_reg.offset_x <= off_reg[0];
                    out_reg.offset_y <= off_reg[1];
                    out_reg.offset_z <= off_reg[2];
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ofe_pkg::ST_IDLE)
        else $error("accepted beat did not start work");

    a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |=> have_reg)
        else $error("sample flag dropped");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ofe_pkg::ST_DONE && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("result beat not loaded");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        ax_reg != 2'd3)
        else $error("axis index out of range");

endmodule

/* hw/rtl/three_axis_one_euro_position_filter.sv */
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_data (opcode, pos_x/y/z, timestamp)
// out       output     out_valid/out_ready  out_data (offset_valid, offset_x/y/z)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One bit-serial multiplier and one restoring divider do all multiplications and
// divisions; they set the item time. A filtered sample takes longer from accept to
// result than a seed sample or recenter. Reset is asynchronous, active low; no
// clearing pass.
// A finished beat waits in the output register while the next beat is accepted.
module three_axis_one_euro_position_filter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ofe_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ofe_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [16:0]   cfg_data
);

    logic [13:0] lat_cut_reg;
    logic [16:0] horizon_reg;

    ofe_pkg::mul_req_t mul_req;
    ofe_pkg::div_req_t div_req;
    logic        mul_done;
    logic        div_done;
    logic [63:0] mul_p;
    logic [63:0] div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_cut_reg <= ofe_pkg::DEFAULT_CUT;
            horizon_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ofe_pkg::REG_LAT_CUT)
                lat_cut_reg <= cfg_data[13:0];
            else if (cfg_index == ofe_pkg::REG_HORIZON)
                horizon_reg <= cfg_data;
        end
    end

    ofe_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_p)
    );

    ofe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    ofe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .lat_cut   (lat_cut_reg),
        .horizon   (horizon_reg),
        .mul_req   (mul_req),
        .mul_done  (mul_done),
        .mul_p     (mul_p),
        .div_req   (div_req),
        .div_done  (div_done),
        .div_q     (div_q)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int STALL_HOLD     = 6000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    ofe_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    ofe_pkg::out_t out_data;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [16:0]   cfg_data;

    three_axis_one_euro_position_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [13:0]        p_cut;
    logic [16:0]        p_horizon;
    logic signed [31:0] p_est [3];
    logic signed [31:0] p_slope [3];
    logic signed [31:0] p_origin [3];
    bit                 p_have;
    bit                 p_origin_set;
    logic [31:0]        p_last;

    ofe_pkg::in_t  pending_beats [$];
    ofe_pkg::out_t expected_offsets [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  hold_count;
    int  fail_count;
    int  beats_in;
    int  beats_out;
    int  idle_cycles;
    int  recenters;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint smooth_gain(longint fc_q8, longint dt);
        longint p;
        p = fc_q8 * dt;
        return (p << 16) / (p + 64'd40743665);
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic void track_axis(int i, longint x, longint dt, longint mincut);
        longint e;
        longint dx;
        longint s;
        longint mag;
        longint fc;
        e = x - longint'(p_est[i]);
        dx = e * 1000000 / dt;
        s = p_slope[i];
        s = s + (dx - s) * smooth_gain(256, dt) / 65536;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        p_slope[i] = s[31:0];
        mag = s < 0 ? -s : s;
        fc = mincut + ((mag * 39322) >>> 24);
        p_est[i] = 32'(longint'(p_est[i]) + e * smooth_gain(fc, dt) / 65536);
    endfunction

    function automatic ofe_pkg::out_t predict_offsets(ofe_pkg::in_t b);
        ofe_pkg::out_t r;
        longint dt;
        longint mc;
        longint lead;
        longint off;
        logic [31:0] diff;
        logic signed [31:0] raw [3];
        raw[0] = b.pos_x;
        raw[1] = b.pos_y;
        raw[2] = b.pos_z;
        if (b.opcode == 1'b0) begin
            if (!p_have) begin
                for (int i = 0; i < 3; i++) begin
                    p_est[i] = raw[i];
                    p_slope[i] = 0;
                end
                p_have = 1;
            end else begin
                diff = b.timestamp - p_last;
                dt = diff;
                if (dt < 1000) dt = 1000;
                if (dt > 200000) dt = 200000;
                mc = p_cut != 0 ? p_cut : 307;
                track_axis(0, raw[0], dt, mc);
                track_axis(1, raw[1], dt, mc);
                track_axis(2, raw[2], dt, mc >> 1);
            end
            p_last = b.timestamp;
            if (!p_origin_set) begin
                for (int i = 0; i < 3; i++) p_origin[i] = p_est[i];
                p_origin_set = 1;
            end
        end else if (p_have) begin
            for (int i = 0; i < 3; i++) p_origin[i] = p_est[i];
        end
        r = '0;
        if (p_have && p_origin_set) begin
            r.offset_valid = 1'b1;
            for (int i = 0; i < 3; i++) begin
                lead = clamp_mag(longint'(p_slope[i]) * longint'(p_horizon) / 1000000, 2621);
                off = clamp_mag(longint'(p_est[i]) + lead - longint'(p_origin[i]), 26214);
                if (i == 0) r.offset_x = off[15:0];
                if (i == 1) r.offset_y = off[15:0];
                if (i == 2) r.offset_z = off[15:0];
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                expected_offsets.push_back(predict_offsets(in_data));
                beats_in++;
                if (in_data.opcode) recenters++;
            end
            if ((!in_valid || in_ready) && pending_beats.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pending_beats.pop_front();
            end else if (!in_valid || in_ready) begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                beats_out++;
                if (expected_offsets.size() == 0) begin
                    $error("unexpected beat %p", out_data);
                    fail_count++;
                end else begin
                    ofe_pkg::out_t e;
                    e = expected_offsets.pop_front();
                    if (out_data.offset_valid !== e.offset_valid) begin
                        $error("offset_valid exp %0d got %0d", e.offset_valid,
                               out_data.offset_valid);
                        fail_count++;
                    end
                    if (out_data.offset_x !== e.offset_x) begin
                        $error("offset_x exp %0d got %0d", e.offset_x, out_data.offset_x);
                        fail_count++;
                    end
                    if (out_data.offset_y !== e.offset_y) begin
                        $error("offset_y exp %0d got %0d", e.offset_y, out_data.offset_y);
                        fail_count++;
                    end
                    if (out_data.offset_z !== e.offset_z) begin
                        $error("offset_z exp %0d got %0d", e.offset_z, out_data.offset_z);
                        fail_count++;
                    end
                end
            end
            if (recv_hold) begin
                out_ready <= 1'b0;
                hold_count++;
                if (hold_count >= STALL_HOLD) recv_hold = 0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || recv_hold)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic ofe_pkg::in_t make_beat(bit op, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [31:0] ts);
        ofe_pkg::in_t b;
        b.opcode = op;
        b.pos_x = x;
        b.pos_y = y;
        b.pos_z = z;
        b.timestamp = ts;
        return b;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == ofe_pkg::REG_LAT_CUT) p_cut = val[13:0];
        else if (idx == ofe_pkg::REG_HORIZON) p_horizon = val;
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || expected_offsets.size() > 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    // random track: mostly smooth head motion with occasional jumps and recenters
    task automatic queue_track(int n);
        logic [31:0] ts;
        logic signed [31:0] base [3];
        ts = $urandom;
        for (int k = 0; k < 3; k++) base[k] = $urandom_range(131072) - 65536;
        for (int j = 0; j < n; j++) begin
            int r;
            r = $urandom_range(99);
            if (r < 70) ts += $urandom_range(14000, 6000);
            else if (r < 80) ts += $urandom_range(999);
            else if (r < 88) ts += $urandom_range(400000, 150000);
            else ts = $urandom;
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(99) < 5) base[k] = $urandom;
                else base[k] += $urandom_range(4000) - 2000;
            end
            pending_beats.push_back(make_beat($urandom_range(99) < 8, base[0], base[1],
                                              base[2], ts));
        end
    endtask

    initial begin
        logic [16:0] cuts [6];
        logic [16:0] hors [6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 16;
        recv_idle_pct = 84;
        recv_hold = 0;
        hold_count = 0;
        fail_count = 0;
        beats_in = 0;
        beats_out = 0;
        idle_cycles = 0;
        recenters = 0;
        p_cut = 14'd307;
        p_horizon = '0;
        p_have = 0;
        p_origin_set = 0;
        p_last = '0;
        for (int i = 0; i < 3; i++) begin
            p_est[i] = 0;
            p_slope[i] = 0;
            p_origin[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: recenter before any sample, seed, extremes, repeats, backward time
        pending_beats.push_back(make_beat(1, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                                          32'hffffffff));
        pending_beats.push_back(make_beat(0, 32'h00010000, 32'h00008000, 32'hffff0000, 32'd100));
        pending_beats.push_back(make_beat(0, 32'h00010000, 32'h00008000, 32'hffff0000, 32'd100));
        pending_beats.push_back(make_beat(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd1100));
        pending_beats.push_back(make_beat(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'd50));
        pending_beats.push_back(make_beat(1, 32'h12345678, 32'h0, 32'h0, 32'h0));
        pending_beats.push_back(make_beat(0, 32'h0, 32'hffffffff, 32'h1, 32'hfffffff0));
        pending_beats.push_back(make_beat(0, 32'h00050000, 32'h0, 32'hfffb0000, 32'h00031000));
        pending_beats.push_back(make_beat(0, 32'h00050000, 32'h0, 32'hfffb0000, 32'h00032000));
        drain();

        write_reg(ofe_pkg::REG_HORIZON, 17'h1ffff);
        write_reg(ofe_pkg::REG_LAT_CUT, 17'd0);
        write_reg(2'd3, 17'd5);
        pending_beats.push_back(make_beat(0, 32'h00020000, 32'h0, 32'h0, 32'h00040000));
        pending_beats.push_back(make_beat(0, 32'hfffe0000, 32'h00030000, 32'h7fff0000,
                                          32'h00041000));
        pending_beats.push_back(make_beat(1, 32'h0, 32'h0, 32'h0, 32'h0));
        drain();
        write_reg(ofe_pkg::REG_LAT_CUT, 17'd1);
        pending_beats.push_back(make_beat(0, 32'h0, 32'h0, 32'h00010000, 32'h00042000));
        pending_beats.push_back(make_beat(0, 32'h0, 32'h0, 32'h00020000, 32'h00044000));
        drain();

        cuts = '{17'd307, 17'd16383, 17'd1, 17'd0, 17'd900, 17'd64};
        hors = '{17'd0, 17'd100000, 17'd20000, 17'h1ffff, 17'd50000, 17'd1};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 84;
                recv_idle_pct = 16;
            end
            if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(ofe_pkg::REG_LAT_CUT, cuts[ph]);
            write_reg(ofe_pkg::REG_HORIZON, hors[ph]);
            if (ph == 1) begin
                hold_count = 0;
                recv_hold = 1;
            end
            queue_track(315);
            drain();
        end

        $display("%0d beats in (%0d recenters), %0d out, six cutoff/horizon settings",
                 beats_in, recenters, beats_out);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
